// File: hdl/gsap_pkg.sv
// Shared widths, constants and codes for the gas sensor averaging block.
// No dependencies; imported by every module of the block except gsap_ram.
package gsap_pkg;

    // Field widths
    localparam int ADC_W      = 12;
    localparam int MV_W       = 12;
    localparam int RS_W       = 25;
    localparam int PPM_W      = 16;
    localparam int RL_W       = 16;
    localparam int R0_W       = 16;
    localparam int TOTAL_W    = 20;
    localparam int CAL_CNT_W  = 8;
    localparam int CAL_TOT_W  = 33;

    // Serial arithmetic units
    localparam int DVD_W      = 33;
    localparam int DVS_W      = 25;
    localparam int MUL_A_W    = 17;
    localparam int MUL_B_W    = 16;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int SQ_X_W     = 33;
    localparam int SQ_R_W     = (SQ_X_W + 1) / 2;

    // Stream and register port widths
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 72;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Default sizes
    localparam int FILTER_DEPTH_DEF = 16;
    localparam int CAL_SAMPLES_DEF  = 50;

    // Reset values
    localparam logic [RL_W-1:0] RL_RESET = 16'd2560;
    localparam logic [R0_W-1:0] R0_RESET = 16'd4992;

    // Conversion constants
    localparam logic [ADC_W-1:0]   ADC_FULL     = 12'd4095;
    localparam logic [ADC_W-1:0]   MV_SCALE     = 12'd3300;
    localparam logic [ADC_W-1:0]   FLOOR_CODE   = 12'd12;
    localparam logic [ADC_W-1:0]   FLOOR_FACTOR = 12'd329;
    localparam logic [MUL_A_W-1:0] Q_SCALE      = 17'd102400;
    localparam logic [SQ_R_W-1:0]  PPM_OFFSET   = 17'd320;

    // Opcodes
    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    // Register index (word address bits of paddr)
    localparam logic [APB_ADDR_W-3:0] REG_LOAD_RES = '0;

endpackage

// File: hdl/gsap_ram.sv
// Generic single-port-write, registered-read RAM.
// Depends on nothing; used for the sample ring.
module gsap_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/gsap_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on gsap_pkg for operand widths.
module gsap_mul import gsap_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MUL_A_W-1:0] mcand,
    input  logic [MUL_B_W-1:0] mplier,
    output logic               done,
    output logic [MUL_P_W-1:0] product
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [MUL_P_W-1:0] p_reg;
    logic [MUL_A_W-1:0] a_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [MUL_A_W:0]   sum;

    // add the multiplicand when the current low bit is set, then shift right
    assign sum = {1'b0, p_reg[MUL_P_W-1:MUL_B_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(MUL_B_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            p_reg <= {{MUL_A_W{1'b0}}, mplier};
            a_reg <= mcand;
        end else if (cnt_reg != '0) begin
            p_reg <= {sum, p_reg[MUL_B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule

// File: hdl/gsap_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on gsap_pkg for operand widths; shared by all divisions of the block.
module gsap_div import gsap_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_shift;
    logic [DVS_W+1:0] diff;
    logic             fits;

    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign fits      = !diff[DVS_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(DVD_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits shift in at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/gsap_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on gsap_pkg for operand widths.
module gsap_sqrt import gsap_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SQ_X_W-1:0] radicand,
    output logic              done,
    output logic [SQ_R_W-1:0] root
);

    localparam int XP_W  = 2 * SQ_R_W;
    localparam int REM_W = SQ_R_W + 2;
    localparam int CNT_W = $clog2(SQ_R_W + 1);

    logic [XP_W-1:0]   x_reg;
    logic [SQ_R_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [REM_W+1:0]  rem_shift;
    logic [REM_W+1:0]  trial;
    logic [REM_W+2:0]  diff;
    logic              fits;

    assign rem_shift = {rem_reg, x_reg[XP_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign diff      = {1'b0, rem_shift} - {1'b0, trial};
    assign fits      = !diff[REM_W+2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(SQ_R_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= XP_W'(radicand);
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (cnt_reg != '0) begin
            x_reg    <= {x_reg[XP_W-3:0], 2'b00};
            root_reg <= {root_reg[SQ_R_W-2:0], fits};
            rem_reg  <= fits ? diff[REM_W-1:0] : rem_shift[REM_W-1:0];
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: hdl/gas_sensor_average_to_ppm.sv
// Gas sensor front end: moving average, millivolts, sensor resistance and ppm.
// Depends on gsap_pkg, gsap_ram, gsap_mul, gsap_div and gsap_sqrt.
//
// Input stream (s_t*): one beat per converter sample, adc_sample in s_tdata,
// opcode in s_tuser (measure or clean-air calibration). Output stream (m_t*):
// one beat per sample with the filtered reading, millivolts, Rs, ppm and flags.
// APB port: register 0 holds the load resistance RL (Q8.8 kOhm).
//
// Most of the time per sample goes to the serial divider, with one division
// each for the average, the millivolts, Rs (skipped at or below the 0.01 V
// floor), the clean-air R0 (only on the beat that completes calibration) and
// ppm (skipped when Rs is zero), plus up to three shift-add multiplies and a
// square root. One sample is processed at a time; the next input beat is
// taken as soon as the previous result sits in the output register.
// A stalled receiver holds the output beat; the block finishes the next sample
// and then waits for the output register to drain.
// Reset (aresetn low, synchronous) empties the averaging window, clears the
// calibration accumulator, restores RL and R0 to their defaults and drops
// m_tvalid. No clearing pass is needed.
module gas_sensor_average_to_ppm import gsap_pkg::*; #(
    parameter int FILTER_DEPTH = FILTER_DEPTH_DEF,
    parameter int CAL_SAMPLES  = CAL_SAMPLES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] adc_sample
    input  logic [0:0]            s_tuser,   // [0] opcode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [11:0] filtered_adc, [23:12] voltage_mv, [48:24] sensor_resistance,
    // [64:49] ppm_value, [65] ppm_saturated, [66] calibration_done
    output logic [M_TDATA_W-1:0]  m_tdata,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PTR_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int CNT_W = $clog2(FILTER_DEPTH + 1);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_READ  = 13'b0000000000010,
        S_DFILT = 13'b0000000000100,
        S_MMV   = 13'b0000000001000,
        S_DMV   = 13'b0000000010000,
        S_MRS   = 13'b0000000100000,
        S_DRS   = 13'b0000001000000,
        S_CAL   = 13'b0000010000000,
        S_DCAL  = 13'b0000100000000,
        S_MQ    = 13'b0001000000000,
        S_DQ    = 13'b0010000000000,
        S_SQRT  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [PTR_W-1:0]       wp_reg, wp_next;
    logic                   full_reg, full_next;
    logic [CAL_CNT_W-1:0]   cal_cnt_reg, cal_cnt_next;
    logic [CAL_TOT_W-1:0]   cal_tot_reg, cal_tot_next;
    logic [R0_W-1:0]        r0_reg, r0_next;
    logic [RL_W-1:0]        rl_reg;
    logic                   m_valid_reg, m_valid_next;

    logic                   op_reg, op_next;
    logic [ADC_W-1:0]       adc_reg, adc_next;
    logic [ADC_W-1:0]       filt_reg, filt_next;
    logic [MV_W-1:0]        mv_reg, mv_next;
    logic [RS_W-1:0]        rs_reg, rs_next;
    logic [PPM_W-1:0]       ppm_reg, ppm_next;
    logic                   sat_reg, sat_next;
    logic                   cdone_reg, cdone_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    logic                   s_accept;
    logic                   wp_last;
    logic [CNT_W-1:0]       fill_cnt;
    logic                   floor_hit;
    logic                   rs_zero;
    logic [CAL_TOT_W-1:0]   cal_sum;
    logic [CAL_CNT_W-1:0]   cal_inc;
    logic                   cal_hit;
    logic [R0_W-1:0]        r0_mean;
    logic [SQ_R_W-1:0]      ppm_diff;

    logic                   ram_wr;
    logic [ADC_W-1:0]       ram_rdata;

    logic                   div_start, div_done;
    logic [DVD_W-1:0]       div_dvd, div_quo;
    logic [DVS_W-1:0]       div_dvs;
    logic                   mul_start, mul_done;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [MUL_P_W-1:0]     mul_prod;
    logic                   sqrt_start, sqrt_done;
    logic [SQ_X_W-1:0]      sqrt_x;
    logic [SQ_R_W-1:0]      sqrt_root;

    logic                   cfg_wr;

    // ---------------------------------------------------------------- units
    gsap_ram #(
        .WIDTH (ADC_W),
        .DEPTH (FILTER_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (wp_reg),
        .wr_data (adc_reg),
        .rd_en   (s_accept),
        .rd_addr (wp_reg),
        .rd_data (ram_rdata)
    );

    gsap_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    gsap_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    gsap_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_x),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // ---------------------------------------------------------- register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_LOAD_RES) ?
                    APB_DATA_W'(rl_reg) : '0;

    // ------------------------------------------------------------- datapath
    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign wp_last   = (wp_reg == PTR_W'(FILTER_DEPTH - 1));
    assign fill_cnt  = (full_reg || wp_last) ? CNT_W'(FILTER_DEPTH)
                                             : CNT_W'(wp_reg) + CNT_W'(1);
    assign floor_hit = (filt_reg <= FLOOR_CODE);
    assign rs_zero   = (rs_reg == '0);
    assign cal_sum   = cal_tot_reg + CAL_TOT_W'(rs_reg);
    assign cal_inc   = cal_cnt_reg + CAL_CNT_W'(1);
    assign cal_hit   = (cal_inc >= CAL_CNT_W'(CAL_SAMPLES));
    assign r0_mean   = (|div_quo[DVD_W-1:R0_W]) ? '1 : div_quo[R0_W-1:0];
    assign ppm_diff  = sqrt_root - PPM_OFFSET;

    always_comb begin
        state_next   = state_reg;
        total_next   = total_reg;
        wp_next      = wp_reg;
        full_next    = full_reg;
        cal_cnt_next = cal_cnt_reg;
        cal_tot_next = cal_tot_reg;
        r0_next      = r0_reg;
        m_valid_next = m_valid_reg;
        op_next      = op_reg;
        adc_next     = adc_reg;
        filt_next    = filt_reg;
        mv_next      = mv_reg;
        rs_next      = rs_reg;
        ppm_next     = ppm_reg;
        sat_next     = sat_reg;
        cdone_next   = cdone_reg;
        m_data_next  = m_data_reg;
        ram_wr       = 1'b0;
        div_start    = 1'b0;
        div_dvd      = '0;
        div_dvs      = '0;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        sqrt_start   = 1'b0;
        sqrt_x       = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    op_next    = s_tuser[0];
                    adc_next   = s_tdata[ADC_W-1:0];
                    state_next = S_READ;
                end
            end
            S_READ: begin
                // drop the oldest sample once the window is full
                total_next = total_reg - (full_reg ? TOTAL_W'(ram_rdata) : '0)
                             + TOTAL_W'(adc_reg);
                ram_wr     = 1'b1;
                if (wp_last) begin
                    wp_next   = '0;
                    full_next = 1'b1;
                end else begin
                    wp_next   = wp_reg + PTR_W'(1);
                end
                div_start  = 1'b1;
                div_dvd    = DVD_W'(total_next);
                div_dvs    = DVS_W'(fill_cnt);
                state_next = S_DFILT;
            end
            S_DFILT: begin
                if (div_done) begin
                    filt_next  = div_quo[ADC_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(div_quo[ADC_W-1:0]);
                    mul_b      = MUL_B_W'(MV_SCALE);
                    state_next = S_MMV;
                end
            end
            S_MMV: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(mul_prod);
                    div_dvs    = DVS_W'(ADC_FULL);
                    state_next = S_DMV;
                end
            end
            S_DMV: begin
                if (div_done) begin
                    mv_next    = div_quo[MV_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(rl_reg);
                    mul_b      = floor_hit ? MUL_B_W'(FLOOR_FACTOR)
                                           : MUL_B_W'(ADC_FULL - filt_reg);
                    state_next = S_MRS;
                end
            end
            S_MRS: begin
                if (mul_done) begin
                    if (floor_hit) begin
                        rs_next    = mul_prod[RS_W-1:0];
                        state_next = S_CAL;
                    end else begin
                        div_start  = 1'b1;
                        div_dvd    = DVD_W'(mul_prod);
                        div_dvs    = DVS_W'(filt_reg);
                        state_next = S_DRS;
                    end
                end
            end
            S_DRS: begin
                if (div_done) begin
                    rs_next    = div_quo[RS_W-1:0];
                    state_next = S_CAL;
                end
            end
            S_CAL: begin
                cdone_next = 1'b0;
                priority if (op_reg == OP_CALIBRATE && cal_hit) begin
                    cal_tot_next = '0;
                    cal_cnt_next = '0;
                    cdone_next   = 1'b1;
                    div_start    = 1'b1;
                    div_dvd      = DVD_W'(cal_sum);
                    div_dvs      = DVS_W'(CAL_SAMPLES);
                    state_next   = S_DCAL;
                end else begin
                    if (op_reg == OP_CALIBRATE) begin
                        cal_tot_next = cal_sum;
                        cal_cnt_next = cal_inc;
                    end
                    if (rs_zero) begin
                        ppm_next   = '1;
                        sat_next   = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        mul_start  = 1'b1;
                        mul_a      = Q_SCALE;
                        mul_b      = MUL_B_W'(r0_reg);
                        state_next = S_MQ;
                    end
                end
            end
            S_DCAL: begin
                if (div_done) begin
                    r0_next = r0_mean;
                    if (rs_zero) begin
                        ppm_next   = '1;
                        sat_next   = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        mul_start  = 1'b1;
                        mul_a      = Q_SCALE;
                        mul_b      = MUL_B_W'(r0_mean);
                        state_next = S_MQ;
                    end
                end
            end
            S_MQ: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(mul_prod);
                    div_dvs    = rs_reg;
                    state_next = S_DQ;
                end
            end
            S_DQ: begin
                if (div_done) begin
                    sqrt_start = 1'b1;
                    sqrt_x     = SQ_X_W'(div_quo);
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    priority if (sqrt_root <= PPM_OFFSET) begin
                        ppm_next = '0;
                        sat_next = 1'b0;
                    end else if (|ppm_diff[SQ_R_W-1:PPM_W]) begin
                        ppm_next = '1;
                        sat_next = 1'b1;
                    end else begin
                        ppm_next = ppm_diff[PPM_W-1:0];
                        sat_next = 1'b0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {5'b00000, cdone_reg, sat_reg, ppm_reg, rs_reg,
                                    mv_reg, filt_reg};
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            wp_reg      <= '0;
            full_reg    <= 1'b0;
            cal_cnt_reg <= '0;
            cal_tot_reg <= '0;
            r0_reg      <= R0_RESET;
            rl_reg      <= RL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            wp_reg      <= wp_next;
            full_reg    <= full_next;
            cal_cnt_reg <= cal_cnt_next;
            cal_tot_reg <= cal_tot_next;
            r0_reg      <= r0_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr && paddr[APB_ADDR_W-1:2] == REG_LOAD_RES) begin
                rl_reg <= pwdata[RL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        adc_reg    <= adc_next;
        filt_reg   <= filt_next;
        mv_reg     <= mv_next;
        rs_reg     <= rs_next;
        ppm_reg    <= ppm_next;
        sat_reg    <= sat_next;
        cdone_reg  <= cdone_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    ap_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_READ)
        else $error("accepted beat did not start the ring update");

    ap_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= PTR_W'(FILTER_DEPTH - 1))
        else $error("ring write pointer out of range");

    ap_cal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_cnt_reg < CAL_CNT_W'(CAL_SAMPLES))
        else $error("calibration count passed its limit");

    ap_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("output beat raised outside the delivery state");

    ap_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[65] |-> m_data_reg[64:49] == '1)
        else $error("saturated ppm not at full scale");
`endif

endmodule

// File: tb/tb.sv
// Testbench for gas_sensor_average_to_ppm: random and directed sample beats,
// result beats checked against an in-bench predictor. Depends on gsap_pkg and gas_sensor_average_to_ppm.
`timescale 1ns / 100ps

module tb;
    import gsap_pkg::*;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [PPM_W-1:0] ppm;
        logic [RS_W-1:0]  rs;
        logic [MV_W-1:0]  mv;
        logic [ADC_W-1:0] filt;
    } gas_result_t;

    class gas_scoreboard;
        logic [RL_W-1:0]    load_res;
        logic [ADC_W-1:0]   window [16];
        int unsigned        wr_pos;
        bit                 full;
        logic [TOTAL_W-1:0] total;
        int unsigned        cal_count;
        logic [CAL_TOT_W-1:0] cal_total;
        logic [R0_W-1:0]    clean_air;
        gas_result_t        pending [$];
        int unsigned        mismatches;

        function new();
            load_res = RL_RESET;
            wr_pos = 0;
            full = 0;
            total = '0;
            cal_count = 0;
            cal_total = '0;
            clean_air = R0_RESET;
            mismatches = 0;
        endfunction

        function automatic longint unsigned isqrt(longint unsigned x);
            longint unsigned r;
            r = 0;
            for (int b = 31; b >= 0; b--)
                if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x)
                    r = r | (64'd1 << b);
            return r;
        endfunction

        function void note_sample(logic op, logic [ADC_W-1:0] adc);
            gas_result_t e;
            int unsigned cnt;
            longint unsigned rs, q, s, mean;
            if (full) total = total - TOTAL_W'(window[wr_pos]);
            window[wr_pos] = adc;
            total = total + TOTAL_W'(adc);
            wr_pos++;
            if (wr_pos >= 16) begin
                wr_pos = 0;
                full = 1;
            end
            cnt = full ? 16 : wr_pos;
            e = '0;
            e.filt = ADC_W'(total / cnt);
            e.mv = MV_W'((32'(e.filt) * 3300) / 4095);
            if (e.filt <= 12) rs = 64'(load_res) * 329;
            else rs = 64'(load_res) * (4095 - e.filt) / e.filt;
            rs = rs & 64'h1FFFFFF;
            e.rs = RS_W'(rs);
            if (op == OP_CALIBRATE) begin
                cal_total = CAL_TOT_W'(cal_total + rs);
                cal_count++;
                if (cal_count >= 50) begin
                    mean = cal_total / 50;
                    clean_air = (mean > 65535) ? 16'hFFFF : mean[15:0];
                    cal_count = 0;
                    cal_total = '0;
                    e.done = 1;
                end
            end
            if (rs == 0) begin
                e.ppm = 16'hFFFF;
                e.sat = 1;
            end else begin
                q = 64'd102400 * clean_air / rs;
                s = isqrt(q);
                if (s <= 320) e.ppm = 0;
                else if (s - 320 > 65535) begin
                    e.ppm = 16'hFFFF;
                    e.sat = 1;
                end else e.ppm = PPM_W'(s - 320);
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            gas_result_t got, e;
            got = data[66:0];
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e || data[M_TDATA_W-1:67] !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp f=%0d mv=%0d rs=%0d ppm=%0d s=%0b d=%0b,",
                              " got f=%0d mv=%0d rs=%0d ppm=%0d s=%0b d=%0b"},
                             e.filt, e.mv, e.rs, e.ppm, e.sat, e.done,
                             got.filt, got.mv, got.rs, got.ppm, got.sat, got.done);
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0] s_tuser;
    logic [M_TDATA_W-1:0] m_tdata;
    logic psel, penable, pwrite, pready;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata, prdata;

    gas_scoreboard sb;
    int unsigned cycles;
    bit hold_off;
    bit stall_mode;

    gas_sensor_average_to_ppm DUT (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_off) m_tready <= 0;
        else if (stall_mode) m_tready <= ($urandom_range(0, 3) == 0);
        else m_tready <= ($urandom_range(0, 7) != 0);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) if ($urandom_range(0, 499) == 0) stall_mode <= ~stall_mode;

    task automatic send_beat(logic op, logic [ADC_W-1:0] adc);
        s_tvalid <= 1;
        s_tdata <= {4'(0), adc};
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(op, adc);
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        idle_gap(1);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_load_res(logic [RL_W-1:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {REG_LOAD_RES, 2'b00};
        pwdata <= {16'($urandom_range(0, 65535)), v};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.load_res = v;
    endtask

    task automatic random_burst(int n, int cal_pct);
        int left;
        left = n;
        while (left > 0) begin
            int len;
            len = $urandom_range(1, 12);
            for (int i = 0; i < len && left > 0; i++, left--)
                send_beat($urandom_range(0, 99) < cal_pct,
                          ADC_W'(($urandom_range(0, 9) == 0) ?
                          (($urandom_range(0, 1)) ? $urandom_range(0, 15)
                                                  : $urandom_range(4080, 4095))
                          : $urandom_range(0, 4095)));
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
        end
    endtask

    initial begin
        sb = new();
        cycles = 0; hold_off = 0; stall_mode = 0;
        aresetn = 0; s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, floor, full scale, both opcodes
        send_beat(OP_MEASURE, 12'd0);
        send_beat(OP_MEASURE, 12'd4095);
        send_beat(OP_CALIBRATE, 12'd12);
        send_beat(OP_MEASURE, 12'd13);
        for (int i = 0; i < 16; i++) send_beat(OP_MEASURE, 12'd4095);
        send_beat(OP_MEASURE, 12'hAAA);
        send_beat(OP_MEASURE, 12'h555);
        drain();

        write_load_res(16'hFFFF);
        // full calibration run with low readings so R0 saturates
        for (int i = 0; i < 60; i++)
            send_beat(OP_CALIBRATE, ADC_W'($urandom_range(0, 20)));
        drain();

        write_load_res(16'd1);
        random_burst(120, 50);
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end
            random_burst(20, 20);
        join
        drain();

        write_load_res(16'd0);
        random_burst(40, 30);
        drain();

        write_load_res(RL_RESET);
        random_burst(200, 40);
        drain();

        write_load_res(RL_W'($urandom_range(1, 65535)));
        random_burst(130, 60);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
